>>> rtl/triangle_barycentric_test_top_macros.svh
// Assertion macros for the barycentric triangle test block.
`ifndef TRIANGLE_BARYCENTRIC_TEST_TOP_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_TEST_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/tbt_pkg.sv
// Shared types for the barycentric triangle test block.
package tbt_pkg;
  typedef struct packed {
    logic degenerate;
    logic inside_res;
  } tbt_flags_t;
endpackage

>>> rtl/tbt_cross.sv
// Cross-product stages: edge deltas, then products, then area and numerators.
module tbt_cross #(
  parameter int CB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic signed [CB-1:0]  ax, ay, bx, by, cx, cy, px, py,
  output logic                  vld_out,
  output logic signed [2*CB+3:0] d_out,
  output logic signed [2*CB+3:0] ns_out,
  output logic signed [2*CB+3:0] nt_out,
  output logic signed [2*CB+3:0] nq_out
);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int NW = 2 * CB + 4;
  logic signed [DW-1:0] abx_r, aby_r, acx_r, acy_r, apx_r, apy_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic                 v1_r, v2_r, v3_r;
  logic signed [NW-1:0] d_nxt, ns_nxt, nt_nxt;
  logic signed [NW-1:0] d_r, ns_r, nt_r, nq_r;

  always_comb begin
    d_nxt  = NW'(p0_r) - NW'(p1_r);
    ns_nxt = NW'(p2_r) - NW'(p3_r);
    nt_nxt = NW'(p4_r) - NW'(p5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      abx_r <= DW'(bx) - DW'(ax);
      aby_r <= DW'(by) - DW'(ay);
      acx_r <= DW'(cx) - DW'(ax);
      acy_r <= DW'(cy) - DW'(ay);
      apx_r <= DW'(px) - DW'(ax);
      apy_r <= DW'(py) - DW'(ay);
      p0_r  <= abx_r * acy_r;
      p1_r  <= aby_r * acx_r;
      p2_r  <= apx_r * acy_r;
      p3_r  <= apy_r * acx_r;
      p4_r  <= abx_r * apy_r;
      p5_r  <= aby_r * apx_r;
      d_r   <= d_nxt;
      ns_r  <= ns_nxt;
      nt_r  <= nt_nxt;
      nq_r  <= d_nxt - ns_nxt - nt_nxt;
    end
  end

  assign vld_out = v3_r;
  assign d_out   = d_r;
  assign ns_out  = ns_r;
  assign nt_out  = nt_r;
  assign nq_out  = nq_r;
endmodule

>>> rtl/tbt_div.sv
// Pipelined restoring divider: one quotient bit per stage, then rounding and saturation.
module tbt_div #(
  parameter int NW = 36,
  parameter int FB = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [FB+1:0] wgt
);
  localparam int QB = FB + 2;
  localparam int ST = QB + 1;
  localparam int RW = NW + 1;
  logic [NW-1:0] n_mag, d_mag;
  logic          neg;
  logic [NW-1:0] dd_r  [ST+1];
  logic [RW-1:0] rem_r [ST+1];
  logic [NW-1:0] nn_r  [ST+1];
  logic [ST-1:0] q_r   [ST+1];
  logic          neg_r [ST+1];
  logic          ovf_r [ST+1];
  logic [ST:0]   mag;
  logic signed [FB+1:0] res;
  localparam logic [ST:0] MAXV = (ST+1)'((1 << (FB + 1)) - 1);

  always_comb begin
    neg   = num[NW-1] ^ den[NW-1];
    n_mag = num[NW-1] ? NW'(-num) : NW'(num);
    d_mag = den[NW-1] ? NW'(-den) : NW'(den);
  end

  // The upper dividend bits preload the remainder; only the low ST quotient bits are formed.
  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0]  <= d_mag;
      nn_r[0]  <= n_mag << (NW - ST);
      rem_r[0] <= RW'(n_mag >> ST);
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= 1'b0;
    end
  end

  for (genvar g = 0; g < ST; g++) begin : g_st
    logic [RW-1:0] tr;
    logic [RW:0]   df;
    logic [NW-1:0] nsh;
    logic          ovf;
    always_comb begin
      tr  = {rem_r[g][RW-2:0], nn_r[g][NW-1]};
      nsh = {nn_r[g][NW-2:0], 1'b0};
      df  = {1'b0, tr} - {2'b0, dd_r[g]};
      if (g == 0)
        ovf = rem_r[g] >= {1'b0, dd_r[g]};
      else
        ovf = ovf_r[g];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[g+1]  <= dd_r[g];
        neg_r[g+1] <= neg_r[g];
        ovf_r[g+1] <= ovf;
        nn_r[g+1]  <= nsh;
        rem_r[g+1] <= df[RW] ? tr : df[RW-1:0];
        q_r[g+1]   <= {q_r[g][ST-2:0], ~df[RW]};
      end
    end
  end

  // The divider works on num*2^(FB+1) so the last quotient bit is the round bit.
  always_comb begin
    mag = ({1'b0, q_r[ST]} + (ST+1)'(1)) >> 1;
    if (ovf_r[ST])
      res = neg_r[ST] ? (FB+2)'(-(1 << (FB + 1))) : (FB+2)'(MAXV);
    else if (neg_r[ST])
      res = (mag > MAXV + 1) ? (FB+2)'(-(1 << (FB + 1))) : (FB+2)'(-mag);
    else
      res = (mag > MAXV) ? (FB+2)'(MAXV) : (FB+2)'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) wgt <= res;
  end
endmodule

>>> rtl/triangle_barycentric_test_top.sv
// Top level of the barycentric point-in-triangle test pipeline.
// Channel | Direction | Payload
// in_     | slave     | tdata: ax, ay, bx, by, cx, cy, px, py (COORD_BITS each)
// out_    | master    | tdata: weight_a, weight_b, weight_c; tuser: inside, degenerate
// One transaction per cycle is accepted while the output is not stalled; the path runs through three
// cross stages, an operand register, one divider stage per quotient bit, a rounding
// register and the output register.
// The whole pipeline advances only when the output register is empty or taken.
// rst_n clears the valid bits only.
module triangle_barycentric_test_top #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [8*COORD_BITS-1:0]      in_tdata,   // ax, ay, bx, by, cx, cy, px, py
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [((3*WEIGHT_FRAC_BITS+6+7)/8)*8-1:0] out_tdata, // weight_a, weight_b, weight_c
  output logic [1:0]                   out_tuser   // inside_res, degenerate
);
  `include "triangle_barycentric_test_top_macros.svh"
  localparam int CB = COORD_BITS;
  localparam int FB = WEIGHT_FRAC_BITS;
  localparam int NW = 2 * CB + 4;
  localparam int WB = FB + 2;
  localparam int OW = ((3 * WB + 7) / 8) * 8;
  localparam int DL = WB + 3;

  logic en;
  logic cv;
  logic signed [NW-1:0] d, ns, nt, nq;
  logic signed [WB-1:0] wa, wb, wc;
  logic [DL-1:0] vld_r;
  tbt_pkg::tbt_flags_t fl_r [DL];
  tbt_pkg::tbt_flags_t fl_nxt;
  logic        ov_r;
  logic [OW-1:0] od_r;
  tbt_pkg::tbt_flags_t of_r;

  assign en = !ov_r || out_tready;
  assign in_tready = en;

  tbt_cross #(.CB(CB)) u_cross (
    .clk, .rst_n, .en, .vld_in(in_tvalid),
    .ax(in_tdata[0*CB +: CB]), .ay(in_tdata[1*CB +: CB]),
    .bx(in_tdata[2*CB +: CB]), .by(in_tdata[3*CB +: CB]),
    .cx(in_tdata[4*CB +: CB]), .cy(in_tdata[5*CB +: CB]),
    .px(in_tdata[6*CB +: CB]), .py(in_tdata[7*CB +: CB]),
    .vld_out(cv), .d_out(d), .ns_out(ns), .nt_out(nt), .nq_out(nq)
  );

  tbt_div #(.NW(NW + FB + 1), .FB(FB)) u_div_a (.clk, .en,
    .num((NW+FB+1)'(nq) <<< (FB + 1)), .den((NW+FB+1)'(d)), .wgt(wa));
  tbt_div #(.NW(NW + FB + 1), .FB(FB)) u_div_b (.clk, .en,
    .num((NW+FB+1)'(ns) <<< (FB + 1)), .den((NW+FB+1)'(d)), .wgt(wb));
  tbt_div #(.NW(NW + FB + 1), .FB(FB)) u_div_c (.clk, .en,
    .num((NW+FB+1)'(nt) <<< (FB + 1)), .den((NW+FB+1)'(d)), .wgt(wc));

  always_comb begin
    fl_nxt.degenerate = (d == '0);
    fl_nxt.inside_res = !fl_nxt.degenerate &&
      (ns == '0 || ns[NW-1] == d[NW-1]) &&
      (nt == '0 || nt[NW-1] == d[NW-1]) &&
      (nq == '0 || nq[NW-1] == d[NW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[DL-2:0], cv};
      ov_r  <= vld_r[DL-1];
    end
    if (en) begin
      fl_r[0] <= fl_nxt;
      for (int i = 1; i < DL; i++) fl_r[i] <= fl_r[i-1];
      of_r <= fl_r[DL-1];
      od_r <= fl_r[DL-1].degenerate ? '0 : OW'({wc, wb, wa});
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {of_r.degenerate, of_r.inside_res};

  `TBT_ASSERT_IMP(a_deg_not_in, clk, rst_n, out_tvalid, !(out_tuser[0] && out_tuser[1]), "inside with zero area")
  `TBT_ASSERT_IMP(a_deg_zero, clk, rst_n, out_tvalid && out_tuser[1], out_tdata == '0, "degenerate weights not zero")
  `TBT_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `TBT_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready, "not ready with empty output")
endmodule

>>> tb/triangle_barycentric_test_top_tb.sv
// Self-checking testbench for the barycentric point-in-triangle test block.
module triangle_barycentric_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int WF = 16;
  localparam int WB = WF + 2;
  localparam int OUT_W = ((3 * WF + 6 + 7) / 8) * 8;
  localparam longint WMAX = (64'sd1 <<< (WF + 1)) - 1;
  localparam longint WMIN = -(64'sd1 <<< (WF + 1));
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct packed {
    logic [WB-1:0] wc;
    logic [WB-1:0] wb;
    logic [WB-1:0] wa;
    logic inside_res;
    logic degen;
  } bary_result_t;

  typedef struct {
    logic [8*CB-1:0] coords;
    logic            known;
    bary_result_t    res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [8*CB-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  bary_result_t pending_weights[$];
  stim_row_t directed_rows[$];
  int errors;
  int checked;
  int idle_cycles;
  int degenerate_seen;
  int inside_seen;

  triangle_barycentric_test_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint cross_of(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic longint rounded_weight(longint num, longint den);
    logic neg;
    longint unsigned n, d, ip, rem, mag;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = num < 0;
    n = neg ? -num : num;
    d = den;
    ip = n / d;
    if (ip >= 2) return neg ? WMIN : WMAX;
    rem = n % d;
    mag = ip;
    for (int i = 0; i < WF; i++) begin
      rem = rem << 1;
      mag = mag << 1;
      if (rem >= d) begin
        rem = rem - d;
        mag = mag | 1;
      end
    end
    if ((rem << 1) >= d) mag = mag + 1;
    if (neg) return -longint'(mag);
    if (mag > WMAX) return WMAX;
    return mag;
  endfunction

  function automatic logic agrees_in_sign(longint num, longint den);
    return (num == 0) || ((num < 0) == (den < 0));
  endfunction

  function automatic bary_result_t barycentric_weights(logic [8*CB-1:0] c);
    bary_result_t r;
    longint v[8];
    longint d, ns, nt, nq;
    for (int i = 0; i < 8; i++) v[i] = longint'($signed(c[i*CB +: CB]));
    d  = cross_of(v[2] - v[0], v[3] - v[1], v[4] - v[0], v[5] - v[1]);
    ns = cross_of(v[6] - v[0], v[7] - v[1], v[4] - v[0], v[5] - v[1]);
    nt = cross_of(v[2] - v[0], v[3] - v[1], v[6] - v[0], v[7] - v[1]);
    nq = d - ns - nt;
    r = '0;
    if (d == 0) begin
      r.degen = 1'b1;
      return r;
    end
    r.inside_res = agrees_in_sign(ns, d) && agrees_in_sign(nt, d) && agrees_in_sign(nq, d);
    r.wa = WB'(rounded_weight(nq, d));
    r.wb = WB'(rounded_weight(ns, d));
    r.wc = WB'(rounded_weight(nt, d));
    return r;
  endfunction

  function automatic logic [8*CB-1:0] pack_coords(int ax, int ay, int bx, int by,
                                                  int cx, int cy, int px, int py);
    logic [CB-1:0] f[8];
    f = '{ax[CB-1:0], ay[CB-1:0], bx[CB-1:0], by[CB-1:0],
          cx[CB-1:0], cy[CB-1:0], px[CB-1:0], py[CB-1:0]};
    return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  function automatic logic [CB-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return CB'($urandom);
      default: return 16'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic logic [8*CB-1:0] random_coords();
    logic [8*CB-1:0] c;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) c[i*CB +: CB] = random_coord();
    if (mode == 0) begin
      c[2*CB +: 2*CB] = c[0 +: 2*CB];
    end else if (mode == 1) begin
      c[6*CB +: CB] = c[2*CB +: CB];
      c[7*CB +: CB] = c[3*CB +: CB];
    end else if (mode < 6) begin
      c[6*CB +: CB] = 16'((int'($signed(c[0 +: CB])) + int'($signed(c[2*CB +: CB]))
                          + int'($signed(c[4*CB +: CB]))) / 3
                          + int'($urandom_range(0, 16)) - 8);
      c[7*CB +: CB] = 16'((int'($signed(c[CB +: CB])) + int'($signed(c[3*CB +: CB]))
                          + int'($signed(c[5*CB +: CB]))) / 3
                          + int'($urandom_range(0, 16)) - 8);
    end
    return c;
  endfunction

  function automatic void add_row(logic [8*CB-1:0] c, logic known, bary_result_t r);
    stim_row_t row;
    row.coords = c;
    row.known = known;
    row.res = r;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(logic [8*CB-1:0] c, bary_result_t want);
    bary_result_t pred;
    pred = barycentric_weights(c);
    if (pred !== want) begin
      $display("%0t predictor disagrees with typed expectation: exp %h act %h",
               $time, want, pred);
      errors++;
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    pending_weights.push_back(want);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  initial begin
    bary_result_t z, unit;
    logic [8*CB-1:0] c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z.degen = 1'b1;
    add_row(pack_coords(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z);
    add_row(pack_coords(-32768, -32768, -32768, -32768, 32767, 32767, 5, 5), 1'b1, z);
    add_row(pack_coords(0, 0, 16, 16, 32, 32, 7, 3), 1'b1, z);
    unit = '0;
    unit.inside_res = 1'b1;
    unit.wa = WB'(1 << WF);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, 0, 0), 1'b1, unit);
    unit.wa = '0;
    unit.wb = WB'(1 << WF);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, 16, 0), 1'b1, unit);
    unit.wb = '0;
    unit.wc = WB'(1 << WF);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, 0, 16), 1'b1, unit);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, 8, 0), 1'b0, z);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, 5, 5), 1'b0, z);
    add_row(pack_coords(0, 0, 0, 16, 16, 0, 5, 5), 1'b0, z);
    add_row(pack_coords(0, 0, 16, 0, 0, 16, -1, 5), 1'b0, z);
    add_row(pack_coords(0, 0, 1, 0, 0, 1, 32767, 32767), 1'b0, z);
    add_row(pack_coords(0, 0, 1, 0, 0, 1, -32768, -32768), 1'b0, z);
    add_row(pack_coords(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0), 1'b0, z);
    add_row(pack_coords(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768),
            1'b0, z);
    add_row(pack_coords(0, 0, 3, 0, 0, 3, 1, 1), 1'b0, z);
    add_row(pack_coords(0, 0, 6, 0, 0, 6, 1, 1), 1'b0, z);
    add_row(pack_coords(-1, -1, -1, 0, 0, -1, -1, -1), 1'b0, z);
    add_row('1, 1'b0, z);

    foreach (directed_rows[i])
      send_item(directed_rows[i].coords, directed_rows[i].known ?
                directed_rows[i].res : barycentric_weights(directed_rows[i].coords));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = random_coords();
      send_item(c, barycentric_weights(c));
    end
    in_tvalid <= 1'b0;
    wait (pending_weights.size() == 0);
    repeat (4 * (WF + 8)) @(posedge clk);
    $display("Checked %0d results (%0d directed rows, %0d random items).",
             checked, directed_rows.size(), RANDOM_ITEMS);
    $display("Degenerate triangles: %0d, samples inside: %0d.", degenerate_seen, inside_seen);
    if (errors == 0) begin
      $display("triangle_barycentric_test_top_tb: done, clean");
    end else begin
      $display("triangle_barycentric_test_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bary_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.degen = out_tuser[1];
      got.inside_res = out_tuser[0];
      got.wa = out_tdata[0 +: WB];
      got.wb = out_tdata[WB +: WB];
      got.wc = out_tdata[2*WB +: WB];
      if (pending_weights.size() == 0) begin
        $display("%0t unexpected transaction: exp none act %h", $time, got);
        errors++;
      end else begin
        want = pending_weights.pop_front();
        checked++;
        degenerate_seen += want.degen;
        inside_seen += want.inside_res;
        if (got.degen !== want.degen) begin
          $display("%0t degenerate: exp %b act %b", $time, want.degen, got.degen);
          errors++;
        end
        if (got.inside_res !== want.inside_res) begin
          $display("%0t inside: exp %b act %b", $time, want.inside_res, got.inside_res);
          errors++;
        end
        if (got.wa !== want.wa) begin
          $display("%0t weight_a: exp %h act %h", $time, want.wa, got.wa);
          errors++;
        end
        if (got.wb !== want.wb) begin
          $display("%0t weight_b: exp %h act %h", $time, want.wb, got.wb);
          errors++;
        end
        if (got.wc !== want.wc) begin
          $display("%0t weight_c: exp %h act %h", $time, want.wc, got.wc);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_barycentric_test_top_tb: done, errors");
        $finish;
      end
    end
  end
endmodule
